FILE: sv/bces_pkg.sv
package bces_pkg;

  localparam int STATE_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int GAIN_W          = 16;
  localparam int CODE_W          = 12;
  localparam int CFG_W           = 32;
  localparam int IDX_W           = 3;
  localparam int VIN_W           = 32;
  localparam int VGAIN_W         = 8;
  localparam int OUT_W           = 32;
  localparam int EXT_W           = 64;

  localparam logic [CODE_W-1:0] CODE_MAX = '1;

  localparam logic [VIN_W-1:0]   VIN_RST    = 32'd3145728;
  localparam logic [GAIN_W-1:0]  DT_L_RST   = 16'd819;
  localparam logic [GAIN_W-1:0]  DT_C_RST   = 16'd6973;
  localparam logic [GAIN_W-1:0]  G_LOAD_RST = 16'd13107;
  localparam logic [VGAIN_W-1:0] VGAIN_RST  = 8'd13;
  localparam logic [CODE_W-1:0]  VOFF_RST   = 12'd96;
  localparam logic [GAIN_W-1:0]  IGAIN_RST  = 16'd6402;

  typedef enum logic [IDX_W-1:0] {
    REG_VIN   = 3'd0,
    REG_DT_L  = 3'd1,
    REG_DT_C  = 3'd2,
    REG_GLOAD = 3'd3,
    REG_VGAIN = 3'd4,
    REG_VOFF  = 3'd5,
    REG_IGAIN = 3'd6
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CURR,
    ST_VOLT,
    ST_VCODE,
    ST_ICODE,
    ST_DONE
  } ctl_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

endpackage

FILE: sv/bces_serial_mul.sv
module bces_serial_mul #(
  parameter int W = bces_pkg::STATE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic signed [W-1:0]            mcand,
  input  logic [bces_pkg::GAIN_W-1:0]    mplier,
  output logic signed [W:0]              prod_hi,
  output logic [bces_pkg::GAIN_W-1:0]    prod_lo,
  output bces_pkg::mul_stat_t            stat
);
  import bces_pkg::*;

  localparam int CW = $clog2(GAIN_W);

  logic signed [W-1:0] mcand_r;
  logic [CW-1:0]       count;
  logic                busy;
  logic                done;
  logic [W+1:0]        sum;

  // one multiplier bit per cycle, lsb first
  assign sum = {prod_hi[W], prod_hi} + (prod_lo[0] ? {{2{mcand_r[W-1]}}, mcand_r} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && count == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand_r <= mcand;
      prod_hi <= '0;
      prod_lo <= mplier;
      count   <= CW'(GAIN_W - 1);
    end else if (busy) begin
      prod_hi <= sum[W+1:1];
      prod_lo <= {sum[0], prod_lo[GAIN_W-1:1]};
      count   <= count - 1'b1;
    end
  end

  assign stat = '{busy: busy, done: done};

endmodule

FILE: sv/bces_dac_codes.sv
module bces_dac_codes #(
  parameter int W = bces_pkg::STATE_WIDTH_DEF,
  parameter int F = bces_pkg::FRAC_BITS_DEF
) (
  input  logic signed [W:0]              prod_hi,
  input  logic [bces_pkg::GAIN_W-1:0]    prod_lo,
  input  logic [bces_pkg::CODE_W-1:0]    offset,
  output logic [bces_pkg::CODE_W-1:0]    vcode,
  output logic [bces_pkg::CODE_W-1:0]    icode
);
  import bces_pkg::*;

  localparam int PW = W + 1 + GAIN_W;
  localparam int QN = W + 1 - F;
  localparam int QW = (QN > CODE_W) ? QN : CODE_W + 1;

  logic [PW-1:0] prod;
  logic [PW-1:0] biased;
  logic [PW-1:0] scaled;
  logic [PW:0]   vdiff;
  logic          positive;
  logic [QW-1:0] qx;

  assign prod = {prod_hi, prod_lo};

  // truncate toward zero
  assign biased = prod + (prod[PW-1] ? PW'({F{1'b1}}) : '0);
  assign scaled = $unsigned($signed(biased) >>> F);
  assign vdiff  = {scaled[PW-1], scaled} - {{(PW+1-CODE_W){1'b0}}, offset};

  assign vcode = (vdiff[PW] || (|vdiff[PW-1:CODE_W])) ? CODE_MAX : vdiff[CODE_W-1:0];

  assign positive = !prod_hi[W] && (|prod);
  assign qx       = QW'(prod_hi[W:F]);

  always_comb begin
    if (!positive) begin
      icode = '0;
    end else if (|qx[QW-1:CODE_W]) begin
      icode = CODE_MAX;
    end else begin
      icode = qx[CODE_W-1:0];
    end
  end

endmodule

FILE: sv/boost_converter_euler_step_unit.sv
// ticks: in_stall holds off a new tick until the sequencer is idle
//   again, set by the single 16-bit bit-serial multiplier, used five
//   times per tick
// the output register lets a new tick be taken while a result waits
// reset: synchronous; clears both states, the output valid and the sequencer,
//   and loads the default register values
module boost_converter_euler_step_unit #(
  parameter int STATE_WIDTH = bces_pkg::STATE_WIDTH_DEF,
  parameter int FRAC_BITS   = bces_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [bces_pkg::IDX_W-1:0]        cfg_index,
  input  logic [bces_pkg::CFG_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              switch_closed,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [bces_pkg::OUT_W-1:0] output_voltage,
  output logic signed [bces_pkg::OUT_W-1:0] inductor_current,
  output logic [bces_pkg::CODE_W-1:0]       voltage_code,
  output logic [bces_pkg::CODE_W-1:0]       current_code
);
  import bces_pkg::*;

  localparam int W    = STATE_WIDTH;
  localparam int SHL  = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int SHR  = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
  localparam int VINW = VIN_W + SHL;
  localparam int DW   = ((VINW > W) ? VINW : W) + 2;

  logic [VIN_W-1:0]   input_voltage;
  logic [GAIN_W-1:0]  step_over_inductance;
  logic [GAIN_W-1:0]  step_over_capacitance;
  logic [GAIN_W-1:0]  load_conductance;
  logic [VGAIN_W-1:0] voltage_dac_gain;
  logic [CODE_W-1:0]  voltage_dac_offset;
  logic [GAIN_W-1:0]  current_dac_gain;

  ctl_state_t state;
  ctl_state_t state_next;

  logic signed [W-1:0] coil_current;
  logic signed [W-1:0] cap_voltage;
  logic                closed_r;
  logic signed [W-1:0] ic_r;
  logic [CODE_W-1:0]   vcode_r;
  logic [CODE_W-1:0]   icode_r;

  logic                mul_start;
  logic signed [W-1:0] mul_a;
  logic [GAIN_W-1:0]   mul_b;
  logic signed [W:0]   mul_hi;
  logic [GAIN_W-1:0]   mul_lo;
  mul_stat_t           mul_stat;
  logic [CODE_W-1:0]   vcode;
  logic [CODE_W-1:0]   icode;
  logic                out_load;

  logic [VINW-1:0]      vin_al;
  logic signed [DW-1:0] vin_d;
  logic signed [DW-1:0] v_d;
  logic signed [DW-1:0] i_d;
  logic signed [DW-1:0] hi_d;
  logic signed [DW-1:0] vl_d;
  logic signed [DW-1:0] ic_d;
  logic signed [DW-1:0] inew_d;
  logic signed [DW-1:0] vnew_d;
  logic signed [EXT_W-1:0] v_ext;
  logic signed [EXT_W-1:0] i_ext;

  function automatic logic signed [W-1:0] sat_w(input logic signed [DW-1:0] x);
    logic fits;
    fits = (x[DW-1:W-1] == '0) || (x[DW-1:W-1] == '1);
    if (fits) begin
      return x[W-1:0];
    end else if (x[DW-1]) begin
      return {1'b1, {(W-1){1'b0}}};
    end else begin
      return {1'b0, {(W-1){1'b1}}};
    end
  endfunction

  bces_serial_mul #(.W(W)) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .mcand   (mul_a),
    .mplier  (mul_b),
    .prod_hi (mul_hi),
    .prod_lo (mul_lo),
    .stat    (mul_stat)
  );

  bces_dac_codes #(.W(W), .F(FRAC_BITS)) u_codes (
    .prod_hi (mul_hi),
    .prod_lo (mul_lo),
    .offset  (voltage_dac_offset),
    .vcode   (vcode),
    .icode   (icode)
  );

  assign vin_al = (VINW'(input_voltage) << SHL) >> SHR;
  assign vin_d  = DW'(vin_al);
  assign v_d    = DW'(cap_voltage);
  assign i_d    = DW'(coil_current);
  assign hi_d   = DW'(mul_hi);
  assign vl_d   = closed_r ? vin_d : vin_d - v_d;
  assign ic_d   = closed_r ? -hi_d : i_d - hi_d;
  assign inew_d = i_d + hi_d;
  assign vnew_d = v_d + hi_d;

  assign in_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      input_voltage         <= VIN_RST;
      step_over_inductance  <= DT_L_RST;
      step_over_capacitance <= DT_C_RST;
      load_conductance      <= G_LOAD_RST;
      voltage_dac_gain      <= VGAIN_RST;
      voltage_dac_offset    <= VOFF_RST;
      current_dac_gain      <= IGAIN_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_VIN:   input_voltage         <= cfg_data[VIN_W-1:0];
        REG_DT_L:  step_over_inductance  <= cfg_data[GAIN_W-1:0];
        REG_DT_C:  step_over_capacitance <= cfg_data[GAIN_W-1:0];
        REG_GLOAD: load_conductance      <= cfg_data[GAIN_W-1:0];
        REG_VGAIN: voltage_dac_gain      <= cfg_data[VGAIN_W-1:0];
        REG_VOFF:  voltage_dac_offset    <= cfg_data[CODE_W-1:0];
        REG_IGAIN: current_dac_gain      <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mul_start  = 1'b0;
    mul_a      = cap_voltage;
    mul_b      = load_conductance;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          mul_start  = 1'b1;
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (mul_stat.done) begin
          mul_start  = 1'b1;
          mul_a      = sat_w(vl_d);
          mul_b      = step_over_inductance;
          state_next = ST_CURR;
        end
      end
      ST_CURR: begin
        if (mul_stat.done) begin
          mul_start  = 1'b1;
          mul_a      = ic_r;
          mul_b      = step_over_capacitance;
          state_next = ST_VOLT;
        end
      end
      ST_VOLT: begin
        if (mul_stat.done) begin
          mul_start  = 1'b1;
          mul_a      = sat_w(vnew_d);
          mul_b      = GAIN_W'(voltage_dac_gain);
          state_next = ST_VCODE;
        end
      end
      ST_VCODE: begin
        if (mul_stat.done) begin
          mul_start  = 1'b1;
          mul_a      = coil_current;
          mul_b      = current_dac_gain;
          state_next = ST_ICODE;
        end
      end
      ST_ICODE: begin
        if (mul_stat.done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coil_current <= '0;
      cap_voltage  <= '0;
    end else begin
      if (state == ST_CURR && mul_stat.done) begin
        coil_current <= sat_w(inew_d);
      end
      if (state == ST_VOLT && mul_stat.done) begin
        cap_voltage <= sat_w(vnew_d);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      closed_r <= switch_closed;
    end
    if (state == ST_LOAD && mul_stat.done) begin
      ic_r <= sat_w(ic_d);
    end
    if (state == ST_VCODE && mul_stat.done) begin
      vcode_r <= vcode;
    end
    if (state == ST_ICODE && mul_stat.done) begin
      icode_r <= icode;
    end
  end

  assign v_ext = EXT_W'(cap_voltage);
  assign i_ext = EXT_W'(coil_current);

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      output_voltage   <= v_ext[OUT_W-1:0];
      inductor_current <= i_ext[OUT_W-1:0];
      voltage_code     <= vcode_r;
      current_code     <= icode_r;
    end
  end

`ifndef SYNTHESIS
  a_accept_starts_mul: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> mul_stat.busy)
    else $error("accepted tick did not start the multiplier");

  a_done_when_waiting: assert property (@(posedge clk) disable iff (rst)
    mul_stat.done |-> (state != ST_IDLE && state != ST_DONE))
    else $error("multiplier finished while the sequencer was not waiting");

  a_coil_hold: assert property (@(posedge clk) disable iff (rst)
    (state != ST_CURR) |=> $stable(coil_current))
    else $error("coil current changed outside its update step");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && !(out_valid && out_stall)) |=> (out_valid && state == ST_IDLE))
    else $error("finished tick not moved to the output register");
`endif

endmodule
